FILE: src/order_book_matcher_macros.svh
// Assertion macros for the order book matcher.
// Used by the top level only; no other dependencies.
`ifndef ORDER_BOOK_MATCHER_MACROS_SVH
`define ORDER_BOOK_MATCHER_MACROS_SVH
`ifndef ASSERT_OFF
`define OBM_ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("assertion failed");
`define OBM_ASSERT_IMPL(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
`define OBM_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define OBM_ASSERT_NEVER(label, clk, rst, cond)
`define OBM_ASSERT_IMPL(label, clk, rst, a, b)
`define OBM_ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

FILE: src/obm_pkg.sv
// Shared types and codes for the order book matcher.
// No dependencies.
`default_nettype none
package obm_pkg;
  localparam int CNT_W = 6;

  localparam logic [2:0] REQ_BUY      = 3'd0;
  localparam logic [2:0] REQ_SELL     = 3'd1;
  localparam logic [2:0] REQ_CANCEL   = 3'd2;
  localparam logic [2:0] REQ_MOD_BUY  = 3'd3;
  localparam logic [2:0] REQ_MOD_SELL = 3'd4;

  localparam logic [2:0] ST_FILLED    = 3'd0;
  localparam logic [2:0] ST_RESTED    = 3'd1;
  localparam logic [2:0] ST_DROPPED   = 3'd2;
  localparam logic [2:0] ST_CANCELLED = 3'd3;
  localparam logic [2:0] ST_REJECT    = 3'd4;
  localparam logic [2:0] ST_FULL      = 3'd5;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] price;
    logic [31:0] qty;
  } entry_t;

  // command to one book, applied to every cell at once
  typedef struct packed {
    logic             shift_en;
    logic [CNT_W-1:0] shift_from;
    logic             load_en;
    logic [CNT_W-1:0] load_idx;
    entry_t           load_data;
    logic             cnt_inc;
    logic             cnt_dec;
  } book_cmd_t;
endpackage
`default_nettype wire

FILE: src/obm_cell.sv
// One slot of a book: holds an entry, takes its upper neighbor on a shift.
// Depends on obm_pkg.
`default_nettype none
module obm_cell #(
  parameter int IDX = 0
) (
  input  wire logic               clk,
  input  wire obm_pkg::book_cmd_t cmd,
  input  wire obm_pkg::entry_t    upper,
  input  wire logic [31:0]        key,
  output obm_pkg::entry_t         entry,
  output logic                    hit
);
  localparam logic [obm_pkg::CNT_W-1:0] MyIdx = obm_pkg::CNT_W'(IDX);

  // load wins over shift
  always_ff @(posedge clk) begin
    if (cmd.load_en && cmd.load_idx == MyIdx) begin
      entry <= cmd.load_data;
    end else if (cmd.shift_en && MyIdx >= cmd.shift_from) begin
      entry <= upper;
    end
  end

  assign hit = (entry.id == key);
endmodule
`default_nettype wire

FILE: src/obm_book.sv
// One packed book: a chain of cells plus the fill count.
// Depends on obm_pkg and obm_cell.
`default_nettype none
module obm_book #(
  parameter int DEPTH = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire obm_pkg::book_cmd_t          cmd,
  input  wire logic [31:0]                 key,
  output obm_pkg::entry_t                  head,
  output logic [obm_pkg::CNT_W-1:0]        count,
  output logic [DEPTH-1:0]                 hits
);
  obm_pkg::entry_t ent [DEPTH+1];
  logic [DEPTH-1:0] raw_hit;

  assign ent[DEPTH] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    obm_cell #(.IDX(i)) u_cell (
      .clk  (clk),
      .cmd  (cmd),
      .upper(ent[i+1]),
      .key  (key),
      .entry(ent[i]),
      .hit  (raw_hit[i])
    );
    assign hits[i] = raw_hit[i] && (obm_pkg::CNT_W'(i) < count);
  end

  assign head = ent[0];

  // fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.cnt_inc && !cmd.cnt_dec) begin
      count <= count + 1'b1;
    end else if (cmd.cnt_dec && !cmd.cnt_inc) begin
      count <= count - 1'b1;
    end
  end
endmodule
`default_nettype wire

FILE: src/order_book_matcher.sv
// Top level of the order book matcher: sequencer, two books, output register.
// Depends on obm_pkg, obm_book and order_book_matcher_macros.svh.
//
// Takes one request at a time. Buy and sell walk the opposite book by
// rotating it once through its chain of cells, one entry a cycle while no
// trade waits on a stalled output. An order goes through accept, start,
// the walk, the end of the walk and status, and a stalled output holds it.
// Cancel goes through accept, find, cancel and status. Modify goes through
// the cancel steps and, if it finds the order, then the order steps.
// Each word out is a trade or the final status; last marks the status word.
`default_nettype none
module order_book_matcher #(
  parameter int BOOK_DEPTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  req_type,
  input  wire logic        good_for_day,
  input  wire logic [31:0] order_price,
  input  wire logic [31:0] order_qty,
  input  wire logic [31:0] order_id,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             is_trade,
  output logic [31:0]      resting_id,
  output logic [31:0]      resting_price,
  output logic [31:0]      trade_qty,
  output logic [31:0]      incoming_id,
  output logic [31:0]      incoming_price,
  output logic [2:0]       status,
  output logic             last
);
`include "order_book_matcher_macros.svh"

  localparam int CW = obm_pkg::CNT_W;
  localparam logic [CW-1:0] DepthC = CW'(BOOK_DEPTH);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_FIND  = 6'b000010,
    S_CANC  = 6'b000100,
    S_START = 6'b001000,
    S_WALK  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state, state_next;
  logic [2:0]  rtype;
  logic        gfd, gfd_next;
  logic [31:0] price, qty, qty_next, key;
  logic        sell_side, sell_side_next;
  logic [2:0]  stat, stat_next;
  logic        resolve, resolve_next;
  logic [CW-1:0] steps, steps_next;
  logic [BOOK_DEPTH-1:0] svec, bvec;

  obm_pkg::book_cmd_t buy_cmd, sell_cmd;
  obm_pkg::entry_t    buy_head, sell_head, head;
  logic [CW-1:0]      buy_cnt, sell_cnt, opp_cnt, own_cnt;
  logic [BOOK_DEPTH-1:0] buy_hits, sell_hits;

  obm_book #(.DEPTH(BOOK_DEPTH)) u_buy (
    .clk(clk), .rst(rst), .cmd(buy_cmd), .key(key),
    .head(buy_head), .count(buy_cnt), .hits(buy_hits)
  );
  obm_book #(.DEPTH(BOOK_DEPTH)) u_sell (
    .clk(clk), .rst(rst), .cmd(sell_cmd), .key(key),
    .head(sell_head), .count(sell_cnt), .hits(sell_hits)
  );

  // newest hit in each book
  logic [CW-1:0] s_idx, b_idx;
  logic s_found, b_found;
  always_comb begin
    s_idx = '0;
    b_idx = '0;
    for (int i = 0; i < BOOK_DEPTH; i++) begin
      if (svec[i]) s_idx = CW'(i);
      if (bvec[i]) b_idx = CW'(i);
    end
  end
  assign s_found = |svec;
  assign b_found = |bvec;

  assign head    = sell_side ? buy_head : sell_head;
  assign opp_cnt = sell_side ? buy_cnt : sell_cnt;
  assign own_cnt = sell_side ? sell_cnt : buy_cnt;

  // walk step arithmetic
  logic [31:0] tq;
  logic crosses, trade, keep, out_free;
  assign tq       = (qty < head.qty) ? qty : head.qty;
  assign crosses  = sell_side ? (price <= head.price) : (price >= head.price);
  assign trade    = (qty != '0) && crosses;
  assign keep     = !(trade && head.qty == tq);
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  logic emit_trade, emit_stat;
  logic [2:0] emit_code;
  obm_pkg::book_cmd_t opp_cmd, own_cmd;

  // sequencer
  always_comb begin
    state_next     = state;
    gfd_next       = gfd;
    qty_next       = qty;
    sell_side_next = sell_side;
    stat_next      = stat;
    resolve_next   = resolve;
    steps_next     = steps;
    buy_cmd        = '0;
    sell_cmd       = '0;
    opp_cmd        = '0;
    own_cmd        = '0;
    emit_trade     = 1'b0;
    emit_stat      = 1'b0;
    emit_code      = stat;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          gfd_next       = good_for_day;
          qty_next       = order_qty;
          sell_side_next = (req_type == obm_pkg::REQ_SELL);
          stat_next      = obm_pkg::ST_REJECT;
          resolve_next   = 1'b0;
          if (req_type == obm_pkg::REQ_BUY || req_type == obm_pkg::REQ_SELL) begin
            if (order_price == '0 || order_qty == '0 || order_id == '0) begin
              state_next = S_DONE;
            end else begin
              state_next = S_START;
            end
          end else if (req_type == obm_pkg::REQ_CANCEL ||
                       req_type == obm_pkg::REQ_MOD_BUY ||
                       req_type == obm_pkg::REQ_MOD_SELL) begin
            state_next = S_FIND;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_FIND: begin
        state_next = S_CANC;
      end
      S_CANC: begin
        if (s_found) begin
          sell_cmd.shift_en   = 1'b1;
          sell_cmd.shift_from = s_idx;
          sell_cmd.cnt_dec    = 1'b1;
        end else if (b_found) begin
          buy_cmd.shift_en   = 1'b1;
          buy_cmd.shift_from = b_idx;
          buy_cmd.cnt_dec    = 1'b1;
        end
        if (rtype == obm_pkg::REQ_CANCEL) begin
          stat_next  = (s_found || b_found) ? obm_pkg::ST_CANCELLED : obm_pkg::ST_REJECT;
          state_next = S_DONE;
        end else if (!(s_found || b_found) || price == '0 || qty == '0) begin
          state_next = S_DONE;
        end else begin
          gfd_next       = 1'b1;
          sell_side_next = (rtype == obm_pkg::REQ_MOD_SELL);
          state_next     = S_START;
        end
      end
      S_START: begin
        steps_next   = opp_cnt;
        resolve_next = 1'b1;
        state_next   = S_WALK;
      end
      S_WALK: begin
        if (steps == '0) begin
          state_next = S_DONE;
        end else if (!trade || out_free) begin
          // rotate head to tail, trimmed or dropped
          opp_cmd.shift_en  = 1'b1;
          opp_cmd.load_en   = keep;
          opp_cmd.load_idx  = opp_cnt - 1'b1;
          opp_cmd.load_data = '{id: head.id, price: head.price,
                                qty: trade ? head.qty - tq : head.qty};
          opp_cmd.cnt_dec   = !keep;
          emit_trade        = trade;
          qty_next          = trade ? qty - tq : qty;
          steps_next        = steps - 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          emit_stat  = 1'b1;
          state_next = S_IDLE;
          if (resolve) begin
            if (qty == '0) begin
              emit_code = obm_pkg::ST_FILLED;
            end else if (!gfd) begin
              emit_code = obm_pkg::ST_DROPPED;
            end else if (own_cnt >= DepthC) begin
              emit_code = obm_pkg::ST_FULL;
            end else begin
              emit_code         = obm_pkg::ST_RESTED;
              own_cmd.load_en   = 1'b1;
              own_cmd.load_idx  = own_cnt;
              own_cmd.load_data = '{id: key, price: price, qty: qty};
              own_cmd.cnt_inc   = 1'b1;
            end
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (state == S_WALK) begin
      if (sell_side) buy_cmd = opp_cmd;
      else           sell_cmd = opp_cmd;
    end else if (state == S_DONE) begin
      if (sell_side) sell_cmd = own_cmd;
      else           buy_cmd = own_cmd;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit_trade || emit_stat) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // request and working registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      rtype <= req_type;
      price <= order_price;
      key   <= order_id;
    end
    if (state == S_FIND) begin
      svec <= (key != '0) ? sell_hits : '0;
      bvec <= (key != '0) ? buy_hits : '0;
    end
    gfd       <= gfd_next;
    qty       <= qty_next;
    sell_side <= sell_side_next;
    stat      <= stat_next;
    resolve   <= resolve_next;
    steps     <= steps_next;
  end

  // output word
  always_ff @(posedge clk) begin
    if (emit_trade) begin
      is_trade       <= 1'b1;
      resting_id     <= head.id;
      resting_price  <= head.price;
      trade_qty      <= tq;
      incoming_id    <= key;
      incoming_price <= price;
      status         <= obm_pkg::ST_FILLED;
      last           <= 1'b0;
    end else if (emit_stat) begin
      is_trade       <= 1'b0;
      resting_id     <= '0;
      resting_price  <= '0;
      trade_qty      <= '0;
      incoming_id    <= key;
      incoming_price <= price;
      status         <= emit_code;
      last           <= 1'b1;
    end
  end

  `OBM_ASSERT_NEVER(a_count_bound, clk, rst, buy_cnt > DepthC || sell_cnt > DepthC)
  `OBM_ASSERT_IMPL(a_trade_not_last, clk, rst, out_valid && is_trade, !last && trade_qty != '0)
  `OBM_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)
  `OBM_ASSERT_NEVER(a_single_emit, clk, rst, emit_trade && emit_stat)
endmodule
`default_nettype wire
